@@ rtl/core/kmhs_pkg.sv @@
// ----------------------------------------------------------------------------
// kmhs_pkg: shared types and constants for the k-mer Hamming search block
// Word formats, action and status codes, controller and datapath signal
// groups, and the residue mismatch count used by the database scan.
// ----------------------------------------------------------------------------
package kmhs_pkg;

    localparam int DB_DEPTH   = 4096;
    localparam int WINDOW_LEN = 9;
    localparam int RES_W      = 5;
    localparam int HIST_LEN   = WINDOW_LEN - 1;
    localparam int WORD_W     = RES_W * WINDOW_LEN;
    localparam int HIST_W     = RES_W * HIST_LEN;
    localparam int ADDR_W     = (DB_DEPTH > 1) ? $clog2(DB_DEPTH) : 1;
    localparam int CNT_W      = $clog2(DB_DEPTH + 1);
    localparam int FILL_W     = $clog2(WINDOW_LEN);
    localparam int HIDX_W     = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int MIN_W      = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W      = 16;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 2;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] word_residues;
        logic [RES_W-1:0]  residue;
        logic              last_residue;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              window_valid;
        logic [MIN_W-1:0]  window_min;
        logic [SUM_W-1:0]  running_total;
        logic              sequence_done;
    } out_word_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic scan_finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic scan_last;
    } dp_sts_t;

    function automatic logic [MIN_W-1:0] mismatches(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b);
        logic [MIN_W-1:0] cnt;
        cnt = '0;
        for (int k = 0; k < WINDOW_LEN; k++) begin
            if (a[k*RES_W +: RES_W] != b[k*RES_W +: RES_W]) begin
                cnt = cnt + MIN_W'(1);
            end
        end
        return cnt;
    endfunction

endpackage

@@ rtl/core/kmhs_ctrl.sv @@
// ----------------------------------------------------------------------------
// kmhs_ctrl: sequencing controller
// Accepts words, and for a scored window steps the datapath through the
// database scan and the final compare.
// ----------------------------------------------------------------------------
module kmhs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kmhs_pkg::dp_sts_t  sts,
    output kmhs_pkg::ctl_cmd_t cmd,
    output logic               busy
);
    import kmhs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        busy            = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (sts.scan_needed)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.scan_finish = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/kmhs_datapath.sv @@
// ----------------------------------------------------------------------------
// kmhs_datapath: word store, query window and scan datapath
// Holds the database memory, the residue history, the running total and the
// result register, and compares one stored word per cycle during a scan.
// ----------------------------------------------------------------------------
module kmhs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  kmhs_pkg::in_word_t  item,
    input  kmhs_pkg::ctl_cmd_t  cmd,
    output kmhs_pkg::dp_sts_t   sts,
    output kmhs_pkg::out_word_t result,
    output logic                result_valid
);
    import kmhs_pkg::*;

    logic [WORD_W-1:0] mem [DB_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              mem_rd;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [WORD_W-1:0] win_reg, win_next;
    logic              last_reg, last_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [MIN_W-1:0]  best_reg, best_next;
    out_word_t         result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic [WORD_W-1:0] win_now;
    logic              fill_full;
    logic [MIN_W-1:0]  m_now;
    logic [MIN_W-1:0]  best_upd;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;

    assign win_now   = {item.residue, hist_reg};
    assign fill_full = (fill_reg >= FILL_W'(HIST_LEN));
    assign m_now     = mismatches(win_reg, rd_data_reg);
    assign best_upd  = (m_now < best_reg) ? m_now : best_reg;
    assign sum_add   = {1'b0, sum_reg} + (SUM_W+1)'(best_upd);
    assign sum_sat   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    assign sts.scan_needed = (item.action == ACT_QUERY) && fill_full && (count_reg != '0);
    assign sts.scan_last   = (CNT_W'(addr_reg) == (count_reg - CNT_W'(1)));

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= item.word_residues;
        end
        if (mem_rd)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_comb
    begin
        count_next        = count_reg;
        hist_next         = hist_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        win_next          = win_reg;
        last_next         = last_reg;
        addr_next         = addr_reg;
        rd_valid_next     = rd_valid_reg;
        best_next         = best_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        mem_we            = 1'b0;
        mem_rd            = 1'b0;

        if (cmd.accept)
        begin
            result_next.status        = STAT_OK;
            result_next.window_valid  = 1'b0;
            result_next.window_min    = '0;
            result_next.running_total = sum_reg;
            result_next.sequence_done = 1'b0;
            result_valid_next         = 1'b1;
            case (item.action)
                ACT_LOAD:
                begin
                    if (count_reg < CNT_W'(DB_DEPTH))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_next.status = STAT_FULL;
                    end
                end
                ACT_CLEAR:
                begin
                    count_next = '0;
                end
                ACT_QUERY:
                begin
                    result_next.sequence_done = item.last_residue;
                    if (fill_full)
                    begin
                        hist_next = win_now[WORD_W-1:RES_W];
                        if (count_reg == '0)
                        begin
                            result_next.status = STAT_EMPTY;
                        end
                        else
                        begin
                            result_valid_next = 1'b0;
                            win_next          = win_now;
                            last_next         = item.last_residue;
                            addr_next         = '0;
                            best_next         = MIN_W'(WINDOW_LEN);
                            rd_valid_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        hist_next[fill_reg[HIDX_W-1:0]*RES_W +: RES_W] = item.residue;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    if (item.last_residue)
                    begin
                        hist_next = '0;
                        fill_next = '0;
                        if (!sts.scan_needed)
                        begin
                            sum_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan_step)
        begin
            mem_rd        = 1'b1;
            addr_next     = addr_reg + ADDR_W'(1);
            rd_valid_next = 1'b1;
            if (rd_valid_reg)
            begin
                best_next = best_upd;
            end
        end

        if (cmd.scan_finish)
        begin
            result_next.status        = STAT_OK;
            result_next.window_valid  = 1'b1;
            result_next.window_min    = best_upd;
            result_next.running_total = sum_sat;
            result_next.sequence_done = last_reg;
            result_valid_next         = 1'b1;
            sum_next                  = last_reg ? '0 : sum_sat;
            rd_valid_next             = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            hist_reg         <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            hist_reg         <= hist_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
            rd_valid_reg     <= rd_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        last_reg   <= last_next;
        addr_reg   <= addr_next;
        best_reg   <= best_next;
        result_reg <= result_next;
    end

endmodule

@@ rtl/core/kmer_min_hamming_search.sv @@
// ----------------------------------------------------------------------------
// kmer_min_hamming_search: minimum Hamming distance search of residue words
// A word on item is taken at a rising edge where start is high and busy is
// low. Its action loads a database word, clears the database, or adds one
// query residue. Every accepted word gives exactly one word on result,
// marked by result_valid for a single cycle; the receiver cannot stall it.
// Loads, clears, unused actions, query residues that do not complete a
// window and windows against an empty database give their result in the
// cycle after acceptance, with busy low, so one such word can be taken every
// cycle. A residue that completes a window against a non-empty database
// scans the stored words at one memory read per cycle; busy stays high
// until the scan ends, and the result appears in the cycle busy falls. The
// scan rate is set by the single read port of the database memory.
// Reset empties the database, clears the residue history and the running
// total, and returns the controller to idle. Database contents are not
// cleared; only entries below the word count are ever read.
// ----------------------------------------------------------------------------
module kmer_min_hamming_search (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  kmhs_pkg::in_word_t  item,
    output logic                busy,
    output kmhs_pkg::out_word_t result,
    output logic                result_valid
);
    import kmhs_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    kmhs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    kmhs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ rtl/core/kmhs_checker.sv @@
// ----------------------------------------------------------------------------
// kmhs_checker: port-level checks for the k-mer Hamming search block
// Checks result consistency and the timing of results against busy.
// ----------------------------------------------------------------------------
module kmhs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input kmhs_pkg::in_word_t  item,
    input logic                busy,
    input kmhs_pkg::out_word_t result,
    input logic                result_valid
);
    import kmhs_pkg::*;

    a_scored_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.window_valid) |-> (result.status == STAT_OK))
        else $error("Scored window reported with a non-ok status.");

    a_unscored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.window_valid) |-> (result.window_min == '0))
        else $error("Unscored result carries a nonzero minimum.");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.action != ACT_QUERY)) |=> result_valid)
        else $error("Non-query word did not give its result in the next cycle.");

    a_scan_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !result_valid)
        else $error("Result shown in the cycle a scan started.");

    a_scan_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("Scan ended without a result.");

endmodule

bind kmer_min_hamming_search kmhs_checker u_kmhs_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for kmer_min_hamming_search
// Drives load, clear, query and unused command words through the start/busy
// handshake with random bursts and gaps. A behavioral scoreboard keeps its own
// word database, residue history and running total, and every result word is
// checked field by field against it or against a typed row's expected word.
// Directed corner words precede random traffic against small databases.
// ----------------------------------------------------------------------------
module tb;

    import kmhs_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};
    localparam int SUM_MAX = 65535;
    localparam int N_DIRECTED = 19;
    localparam int N_RANDOM = 120;

    localparam out_word_t QUIET = '0;
    localparam out_word_t NO_WORDS = '{STAT_EMPTY, 1'b0, 4'd0, 16'd0, 1'b0};
    localparam out_word_t SHORT_DONE = '{STAT_OK, 1'b0, 4'd0, 16'd0, 1'b1};

    typedef struct {
        in_word_t  stim;
        bit        typed;
        out_word_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_word_t  item;
    logic      busy;
    out_word_t result;
    logic      result_valid;

    logic [WORD_W-1:0] db_words [DB_DEPTH];
    int                db_count;
    logic [HIST_W-1:0] hist;
    int                hist_fill;
    int                seq_sum;

    out_word_t pending_results [$];
    int        fail_count;
    int        burst_left;
    dir_row_t  dir_rows [N_DIRECTED];

    kmer_min_hamming_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb: errors");
        $finish;
    end

    function automatic out_word_t search_step(input in_word_t w);
        out_word_t         r;
        logic [WORD_W-1:0] win;
        int                best;
        int                miss;
        r = '0;
        case (w.action)
            ACT_LOAD:
            begin
                if (db_count < DB_DEPTH)
                begin
                    db_words[db_count] = w.word_residues;
                    db_count++;
                end
                else
                begin
                    r.status = STAT_FULL;
                end
            end
            ACT_CLEAR:
            begin
                db_count = 0;
            end
            ACT_QUERY:
            begin
                if (hist_fill >= HIST_LEN)
                begin
                    win = {w.residue, hist};
                    if (db_count == 0)
                    begin
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        best = WINDOW_LEN;
                        for (int i = 0; i < db_count; i++)
                        begin
                            miss = 0;
                            for (int k = 0; k < WINDOW_LEN; k++)
                            begin
                                if (win[k*RES_W +: RES_W] != db_words[i][k*RES_W +: RES_W])
                                begin
                                    miss++;
                                end
                            end
                            if (miss < best)
                            begin
                                best = miss;
                            end
                        end
                        r.window_valid = 1'b1;
                        r.window_min = MIN_W'(best);
                        seq_sum += best;
                        if (seq_sum > SUM_MAX)
                        begin
                            seq_sum = SUM_MAX;
                        end
                    end
                    hist = win[WORD_W-1:RES_W];
                end
                else
                begin
                    hist[hist_fill*RES_W +: RES_W] = w.residue;
                    hist_fill++;
                end
                r.sequence_done = w.last_residue;
            end
            default:
            begin
            end
        endcase
        r.running_total = SUM_W'(seq_sum);
        if (r.sequence_done)
        begin
            hist = '0;
            hist_fill = 0;
            seq_sum = 0;
        end
        return r;
    endfunction

    task automatic send_word(input in_word_t stim, input bit typed, input out_word_t want);
        out_word_t predicted;
        int        gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        item <= stim;
        @(posedge clk);
        while (busy) @(posedge clk);
        predicted = search_step(stim);
        if (typed)
        begin
            predicted = want;
        end
        pending_results = {pending_results, predicted};
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t tb: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t tb: unexpected result word, expected none, actual %p",
                         $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, result.status);
                check_field("window_valid", want.window_valid, result.window_valid);
                check_field("window_min", want.window_min, result.window_min);
                check_field("running_total", want.running_total, result.running_total);
                check_field("sequence_done", want.sequence_done, result.sequence_done);
            end
        end
    end

    initial
    begin
        in_word_t stim;
        int       pick;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        fail_count = 0;
        burst_left = 0;
        db_count = 0;
        hist = '0;
        hist_fill = 0;
        seq_sum = 0;

        dir_rows = '{
            '{'{ACT_QUERY, 45'd0, 5'd31, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd31, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd0, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd0, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd21, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd10, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd31, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd0, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd31, 1'b0}, 1'b1, NO_WORDS},
            '{'{ACT_UNUSED, WORD_ONES, 5'd31, 1'b1}, 1'b1, QUIET},
            '{'{ACT_CLEAR, 45'd0, 5'd0, 1'b0}, 1'b1, QUIET},
            '{'{ACT_LOAD, WORD_ONES, 5'd0, 1'b0}, 1'b1, QUIET},
            '{'{ACT_LOAD, 45'd0, 5'd0, 1'b0}, 1'b1, QUIET},
            '{'{ACT_LOAD, 45'h0A95_2A54_A952, 5'd0, 1'b0}, 1'b1, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd31, 1'b0}, 1'b0, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd0, 1'b1}, 1'b0, QUIET},
            '{'{ACT_QUERY, 45'd0, 5'd17, 1'b1}, 1'b1, SHORT_DONE},
            '{'{ACT_QUERY, WORD_ONES, 5'd0, 1'b0}, 1'b1, QUIET},
            '{'{ACT_CLEAR, WORD_ONES, 5'd31, 1'b1}, 1'b1, QUIET}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < N_DIRECTED; n++)
        begin
            send_word(dir_rows[n].stim, dir_rows[n].typed, dir_rows[n].want);
        end
        wait_all_results();

        stim = '0;
        stim.action = ACT_CLEAR;
        send_word(stim, 1'b0, QUIET);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            stim = '0;
            pick = $urandom_range(0, 99);
            if (pick < 14 && db_count < 10)
            begin
                stim.action = ACT_LOAD;
                case ($urandom_range(0, 2))
                    0:
                    begin
                        stim.word_residues = WORD_W'({$urandom, $urandom});
                    end
                    1:
                    begin
                        for (int k = 0; k < WINDOW_LEN; k++)
                        begin
                            stim.word_residues[k*RES_W +: RES_W] = RES_W'($urandom_range(0, 1));
                        end
                    end
                    default:
                    begin
                        stim.word_residues = {RES_W'($urandom_range(0, 31)), hist};
                    end
                endcase
            end
            else if (pick < 17)
            begin
                stim.action = ACT_CLEAR;
            end
            else if (pick < 20)
            begin
                stim.action = ACT_UNUSED;
                stim.word_residues = WORD_W'({$urandom, $urandom});
                stim.residue = RES_W'($urandom_range(0, 31));
                stim.last_residue = 1'($urandom_range(0, 1));
            end
            else
            begin
                stim.action = ACT_QUERY;
                stim.residue = ($urandom_range(0, 9) < 6) ? RES_W'($urandom_range(0, 1))
                                                          : RES_W'($urandom_range(0, 31));
                stim.last_residue = ($urandom_range(0, 14) == 0);
            end
            send_word(stim, 1'b0, QUIET);
        end

        wait_all_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/kmhs_pkg.sv
rtl/core/kmhs_ctrl.sv
rtl/core/kmhs_datapath.sv
rtl/core/kmer_min_hamming_search.sv
rtl/core/kmhs_checker.sv
tb/tb.sv
